### design/stt_pkg.sv
// Shared types, constants and keyword tables for the source text tokenizer.
package stt_pkg;

  // Widths of the location and identifier length counters and of the number value.
  localparam int POSITION_BITS     = 16;
  localparam int IDENT_LENGTH_BITS = 8;
  localparam int NUMBER_BITS       = 64;

  // Depth of the classified character queue and of the result buffer.
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int RESULT_DEPTH     = 4;
  localparam int RESULT_PTR_BITS  = $clog2(RESULT_DEPTH);
  localparam int RESULT_CNT_BITS  = $clog2(RESULT_DEPTH + 1);

  // Character codes with a meaning of their own.
  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_HASH       = 8'h23;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  // Number of keywords and the value all candidates start from.
  localparam int         KEYWORD_COUNT = 4;
  localparam logic [3:0] KW_ALL        = 4'hF;

  // Keyword codes.
  localparam logic [1:0] KW_RETURN = 2'd0;
  localparam logic [1:0] KW_LET    = 2'd1;
  localparam logic [1:0] KW_IF     = 2'd2;
  localparam logic [1:0] KW_WHILE  = 2'd3;

  // Operator codes.
  localparam logic [1:0] OP_PLUS  = 2'd0;
  localparam logic [1:0] OP_MINUS = 2'd1;
  localparam logic [1:0] OP_STAR  = 2'd2;
  localparam logic [1:0] OP_SLASH = 2'd3;

  // Kinds of result the tokenizer reports.
  typedef enum logic [3:0] {
    TK_NUMBER     = 4'd0,
    TK_IDENT      = 4'd1,
    TK_KEYWORD    = 4'd2,
    TK_OPERATOR   = 4'd3,
    TK_SEMICOLON  = 4'd4,
    TK_COLON      = 4'd5,
    TK_EQUALS     = 4'd6,
    TK_LPAREN     = 4'd7,
    TK_RPAREN     = 4'd8,
    TK_LBRACE     = 4'd9,
    TK_RBRACE     = 4'd10,
    TK_NUM_LETTER = 4'd11,
    TK_BAD_CHAR   = 4'd12,
    TK_END        = 4'd13
  } token_kind_t;

  // Character classes found by the front end.
  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_NEWLINE,
    CLS_SPACE,
    CLS_HASH,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_UNDERSCORE,
    CLS_PUNCT,
    CLS_BAD
  } char_class_t;

  // Scanner modes of the back end.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_COMMENT,
    MODE_HALT
  } scan_mode_t;

  // One classified character with its location.
  typedef struct packed {
    char_class_t              cls;
    token_kind_t              punct_kind;
    logic [1:0]               op;
    logic [3:0]               digit;
    logic [7:0]               ch;
    logic [POSITION_BITS-1:0] row;
    logic [POSITION_BITS-1:0] col;
  } cls_item_t;

  // One result as it leaves the block.
  typedef struct packed {
    token_kind_t                  kind;
    logic [POSITION_BITS-1:0]     row;
    logic [POSITION_BITS-1:0]     col;
    logic [NUMBER_BITS-1:0]       value;
    logic [1:0]                   kw;
    logic [1:0]                   op;
    logic [IDENT_LENGTH_BITS-1:0] len;
    logic                         last;
  } result_t;

  // Up to two results written by the scanner in one cycle.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // Length of each keyword.
  function automatic logic [2:0] kw_length(input logic [1:0] id);
    logic [2:0] len;
    unique case (id)
      KW_RETURN: len = 3'd6;
      KW_LET:    len = 3'd3;
      KW_IF:     len = 3'd2;
      default:   len = 3'd5;
    endcase
    return len;
  endfunction

  // Character of a keyword at a given index; zero past its end.
  function automatic logic [7:0] kw_letter(input logic [1:0] id, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (id)
      KW_RETURN: begin
        unique case (idx)
          3'd0: c = "r";
          3'd1: c = "e";
          3'd2: c = "t";
          3'd3: c = "u";
          3'd4: c = "r";
          3'd5: c = "n";
          default: c = 8'h00;
        endcase
      end
      KW_LET: begin
        unique case (idx)
          3'd0: c = "l";
          3'd1: c = "e";
          3'd2: c = "t";
          default: c = 8'h00;
        endcase
      end
      KW_IF: begin
        unique case (idx)
          3'd0: c = "i";
          3'd1: c = "f";
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0: c = "w";
          3'd1: c = "h";
          3'd2: c = "i";
          3'd3: c = "l";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

### design/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
//   Channel   Direction  Handshake        Payload
//   chars     in         push / full      char_code
//   results   out        pop / empty      token_kind, start_row, start_column,
//                                         number_value, keyword_id, operator_id,
//                                         ident_length, last_of_run
//
// One character is taken per clock while the character queue has room; it is written into
// the character queue, and from its head the scanner writes the first result into the
// result buffer, whose head drives the result ports.
// A character that closes a token can give two results; the scanner waits for two free
// result slots, so a run of such characters is limited by the drain of one result per cycle.
// Reset is synchronous and clears the location, scanner state and both queues.
// Either side may stall on its own: the character queue absorbs a stalled scanner,
// and the result buffer absorbs a stalled reader.
module source_text_tokenizer import stt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   char_code,
  output logic                         empty,
  input  logic                         pop,
  output logic [3:0]                   token_kind,
  output logic [POSITION_BITS-1:0]     start_row,
  output logic [POSITION_BITS-1:0]     start_column,
  output logic [NUMBER_BITS-1:0]       number_value,
  output logic [1:0]                   keyword_id,
  output logic [1:0]                   operator_id,
  output logic [IDENT_LENGTH_BITS-1:0] ident_length,
  output logic                         last_of_run
);

  logic         item_push;
  cls_item_t    front_item;
  logic         q_valid;
  cls_item_t    q_item;
  logic         take;
  logic         space_ok;
  result_pair_t results;
  result_t      head;

  // Character classification and location tracking.
  stt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .item_push (item_push),
    .item      (front_item)
  );

  // Queue between the front end and the scanner.
  stt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (item_push),
    .wr_item  (front_item),
    .full     (full),
    .rd_en    (take),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  // Token scanner.
  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .space_ok   (space_ok),
    .item_take  (take),
    .results    (results)
  );

  // Result buffer feeding the output ports.
  stt_result_buffer u_results (
    .clk      (clk),
    .rst      (rst),
    .results  (results),
    .space_ok (space_ok),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // Result fields onto their ports.
  assign token_kind   = head.kind;
  assign start_row    = head.row;
  assign start_column = head.col;
  assign number_value = head.value;
  assign keyword_id   = head.kw;
  assign operator_id  = head.op;
  assign ident_length = head.len;
  assign last_of_run  = head.last;

endmodule

### design/stt_front.sv
// Front end: classifies each source character and tracks its row and column.
module stt_front import stt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  logic [7:0] char_code,
  output logic      item_push,
  output cls_item_t item
);

  logic [POSITION_BITS-1:0] row;
  logic [POSITION_BITS-1:0] col;
  logic                     accept;

  assign accept    = push && !full;
  assign item_push = accept;

  // Classify the character and attach the punctuation kind it maps to.
  always_comb begin
    item            = '0;
    item.ch         = char_code;
    item.row        = row;
    item.col        = col;
    item.digit      = char_code[3:0];
    item.punct_kind = TK_OPERATOR;
    item.op         = OP_PLUS;
    item.cls        = CLS_BAD;
    priority if (char_code == CHAR_NUL) begin
      item.cls = CLS_NUL;
    end else if (char_code == CHAR_NEWLINE) begin
      item.cls = CLS_NEWLINE;
    end else if (char_code == " " || (char_code >= 8'd9 && char_code <= 8'd13)) begin
      item.cls = CLS_SPACE;
    end else if (char_code == CHAR_HASH) begin
      item.cls = CLS_HASH;
    end else if (char_code >= "0" && char_code <= "9") begin
      item.cls = CLS_DIGIT;
    end else if ((char_code >= "a" && char_code <= "z") ||
                 (char_code >= "A" && char_code <= "Z")) begin
      item.cls = CLS_ALPHA;
    end else if (char_code == CHAR_UNDERSCORE) begin
      item.cls = CLS_UNDERSCORE;
    end else begin
      item.cls = CLS_PUNCT;
      unique case (char_code)
        "+": begin item.punct_kind = TK_OPERATOR; item.op = OP_PLUS;  end
        "-": begin item.punct_kind = TK_OPERATOR; item.op = OP_MINUS; end
        "*": begin item.punct_kind = TK_OPERATOR; item.op = OP_STAR;  end
        "/": begin item.punct_kind = TK_OPERATOR; item.op = OP_SLASH; end
        ";": item.punct_kind = TK_SEMICOLON;
        ":": item.punct_kind = TK_COLON;
        "=": item.punct_kind = TK_EQUALS;
        "(": item.punct_kind = TK_LPAREN;
        ")": item.punct_kind = TK_RPAREN;
        "{": item.punct_kind = TK_LBRACE;
        "}": item.punct_kind = TK_RBRACE;
        default: item.cls = CLS_BAD;
      endcase
    end
  end

  // Location counters: a newline starts the next row, end of text restarts at 1:1.
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= POSITION_BITS'(1);
      col <= POSITION_BITS'(1);
    end else if (accept) begin
      if (char_code == CHAR_NUL) begin
        row <= POSITION_BITS'(1);
        col <= POSITION_BITS'(1);
      end else if (char_code == CHAR_NEWLINE) begin
        if (row != '1) begin
          row <= row + POSITION_BITS'(1);
        end
        col <= POSITION_BITS'(1);
      end else if (col != '1) begin
        col <= col + POSITION_BITS'(1);
      end
    end
  end

endmodule

### design/stt_queue.sv
// Short queue of classified characters between the front end and the scanner.
module stt_queue import stt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  cls_item_t wr_item,
  output logic      full,
  input  logic      rd_en,
  output logic      rd_valid,
  output cls_item_t rd_item
);

  cls_item_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      do_wr;
  logic                      do_rd;

  assign full     = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Storage for queued characters.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      count <= count + QUEUE_CNT_BITS'(do_wr) - QUEUE_CNT_BITS'(do_rd);
    end
  end

endmodule

### design/stt_back.sv
// Back end: the token scanner that turns classified characters into results.
module stt_back import stt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  cls_item_t    item,
  input  logic         space_ok,
  output logic         item_take,
  output result_pair_t results
);

  scan_mode_t                   mode, mode_next;
  logic [POSITION_BITS-1:0]     token_row, token_row_next;
  logic [POSITION_BITS-1:0]     token_col, token_col_next;
  logic [NUMBER_BITS-1:0]       acc, acc_next;
  logic [IDENT_LENGTH_BITS-1:0] ident_count, ident_count_next;
  logic [3:0]                   cands, cands_next;

  logic [NUMBER_BITS+3:0]       acc_wide;
  logic [NUMBER_BITS-1:0]       acc_step;
  result_t                      idle_res;
  logic                         idle_emit;
  scan_mode_t                   idle_mode;
  logic                         start_num;
  logic                         start_ident;
  logic                         use_idle;
  logic                         idle_second;
  result_t                      ident_res;
  result_t                      res0, res1;
  logic [1:0]                   n;

  assign item_take = item_valid && space_ok;

  // Drop keyword candidates that no longer match at this index.
  function automatic logic [3:0] kw_track(input logic [3:0] c_in, input logic [7:0] ch,
                                          input logic [IDENT_LENGTH_BITS-1:0] idx);
    logic [3:0] c_out;
    c_out = c_in;
    for (int i = 0; i < KEYWORD_COUNT; i++) begin
      if (idx >= IDENT_LENGTH_BITS'(kw_length(2'(i))) ||
          kw_letter(2'(i), idx[2:0]) != ch) begin
        c_out[i] = 1'b0;
      end
    end
    return c_out;
  endfunction

  // Decimal step: acc * 10 + digit, saturating at all ones.
  always_comb begin
    acc_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUMBER_BITS + 4)'(item.digit);
    acc_step = (acc_wide[NUMBER_BITS+3:NUMBER_BITS] != 4'b0) ? '1 : acc_wide[NUMBER_BITS-1:0];
  end

  // Result for a finished identifier: a keyword when a candidate matches in full.
  always_comb begin
    ident_res      = '0;
    ident_res.kind = TK_IDENT;
    ident_res.row  = token_row;
    ident_res.col  = token_col;
    ident_res.len  = ident_count;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (cands[i] && ident_count == IDENT_LENGTH_BITS'(kw_length(2'(i)))) begin
        ident_res.kind = TK_KEYWORD;
        ident_res.kw   = 2'(i);
        ident_res.len  = '0;
      end
    end
  end

  // Scan of a character that starts a new token.
  always_comb begin
    idle_res     = '0;
    idle_res.row = item.row;
    idle_res.col = item.col;
    idle_emit    = 1'b0;
    idle_mode    = MODE_IDLE;
    start_num    = 1'b0;
    start_ident  = 1'b0;
    unique case (item.cls)
      CLS_NUL: begin
        idle_emit     = 1'b1;
        idle_res.kind = TK_END;
      end
      CLS_NEWLINE, CLS_SPACE: begin
        idle_mode = MODE_IDLE;
      end
      CLS_HASH: begin
        idle_mode = MODE_COMMENT;
      end
      CLS_DIGIT: begin
        idle_mode = MODE_NUMBER;
        start_num = 1'b1;
      end
      CLS_ALPHA, CLS_UNDERSCORE: begin
        idle_mode   = MODE_IDENT;
        start_ident = 1'b1;
      end
      CLS_PUNCT: begin
        idle_emit     = 1'b1;
        idle_res.kind = item.punct_kind;
        idle_res.op   = item.op;
      end
      default: begin
        idle_emit     = 1'b1;
        idle_res.kind = TK_BAD_CHAR;
        idle_mode     = MODE_HALT;
      end
    endcase
  end

  // Scanner next state and results for the character at the queue head.
  always_comb begin
    mode_next        = mode;
    token_row_next   = token_row;
    token_col_next   = token_col;
    acc_next         = acc;
    ident_count_next = ident_count;
    cands_next       = cands;
    res0             = '0;
    res1             = '0;
    n                = 2'd0;
    use_idle         = 1'b0;
    idle_second      = 1'b0;

    unique case (mode)
      MODE_NUMBER: begin
        if (item.cls == CLS_DIGIT) begin
          acc_next = acc_step;
        end else if (item.cls == CLS_ALPHA) begin
          res0.kind = TK_NUM_LETTER;
          res0.row  = item.row;
          res0.col  = item.col;
          n         = 2'd1;
          mode_next = MODE_HALT;
        end else begin
          res0.kind   = TK_NUMBER;
          res0.row    = token_row;
          res0.col    = token_col;
          res0.value  = acc;
          n           = 2'd1;
          use_idle    = 1'b1;
          idle_second = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (item.cls == CLS_ALPHA || item.cls == CLS_DIGIT || item.cls == CLS_UNDERSCORE) begin
          cands_next = kw_track(cands, item.ch, ident_count);
          if (ident_count != '1) begin
            ident_count_next = ident_count + IDENT_LENGTH_BITS'(1);
          end
        end else begin
          res0        = ident_res;
          n           = 2'd1;
          use_idle    = 1'b1;
          idle_second = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (item.cls == CLS_NEWLINE) begin
          mode_next = MODE_IDLE;
        end else if (item.cls == CLS_NUL) begin
          use_idle = 1'b1;
        end
      end
      MODE_HALT: begin
        if (item.cls == CLS_NUL) begin
          use_idle = 1'b1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase

    // Apply the start-of-token scan, placing its result after any flushed token.
    if (use_idle) begin
      mode_next = idle_mode;
      if (start_num) begin
        token_row_next = item.row;
        token_col_next = item.col;
        acc_next       = NUMBER_BITS'(item.digit);
      end
      if (start_ident) begin
        token_row_next   = item.row;
        token_col_next   = item.col;
        cands_next       = kw_track(KW_ALL, item.ch, '0);
        ident_count_next = IDENT_LENGTH_BITS'(1);
      end
      if (idle_emit) begin
        if (idle_second) begin
          res1 = idle_res;
          n    = 2'd2;
        end else begin
          res0 = idle_res;
          n    = 2'd1;
        end
      end
    end

    // End of text returns the scanner to its reset state.
    if (item.cls == CLS_NUL) begin
      mode_next        = MODE_IDLE;
      token_row_next   = POSITION_BITS'(1);
      token_col_next   = POSITION_BITS'(1);
      acc_next         = '0;
      ident_count_next = '0;
      cands_next       = KW_ALL;
    end

    // Mark the final result caused by this character.
    if (n == 2'd2) begin
      res1.last = 1'b1;
    end else if (n == 2'd1) begin
      res0.last = 1'b1;
    end

    results.count  = item_take ? n : 2'd0;
    results.first  = res0;
    results.second = res1;
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      token_row   <= POSITION_BITS'(1);
      token_col   <= POSITION_BITS'(1);
      acc         <= '0;
      ident_count <= '0;
      cands       <= KW_ALL;
    end else if (item_take) begin
      mode        <= mode_next;
      token_row   <= token_row_next;
      token_col   <= token_col_next;
      acc         <= acc_next;
      ident_count <= ident_count_next;
      cands       <= cands_next;
    end
  end

endmodule

### design/stt_result_buffer.sv
// Output buffer that takes up to two results a cycle and hands out one.
module stt_result_buffer import stt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  result_pair_t results,
  output logic         space_ok,
  input  logic         pop,
  output logic         empty,
  output result_t      head
);

  result_t                    entries [RESULT_DEPTH];
  logic [RESULT_PTR_BITS-1:0] wr_ptr;
  logic [RESULT_PTR_BITS-1:0] rd_ptr;
  logic [RESULT_CNT_BITS-1:0] count;
  logic                       do_rd;

  // Room for a full pair is judged from the stored count alone.
  assign space_ok = (count <= RESULT_CNT_BITS'(RESULT_DEPTH - 2));
  assign empty    = (count == '0);
  assign head     = entries[rd_ptr];
  assign do_rd    = pop && !empty;

  // Result storage.
  always_ff @(posedge clk) begin
    if (results.count != 2'd0) begin
      entries[wr_ptr] <= results.first;
    end
    if (results.count == 2'd2) begin
      entries[wr_ptr + RESULT_PTR_BITS'(1)] <= results.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RESULT_PTR_BITS'(results.count);
      if (do_rd) begin
        rd_ptr <= rd_ptr + RESULT_PTR_BITS'(1);
      end
      count <= count + RESULT_CNT_BITS'(results.count) - RESULT_CNT_BITS'(do_rd);
    end
  end

endmodule

### design/stt_checker.sv
// Port-level checks for the source text tokenizer and their binding.
module stt_checker import stt_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         empty,
  input logic                         pop,
  input logic [3:0]                   token_kind,
  input logic [POSITION_BITS-1:0]     start_row,
  input logic [NUMBER_BITS-1:0]       number_value,
  input logic [IDENT_LENGTH_BITS-1:0] ident_length,
  input logic                         last_of_run
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // The end-of-text result always closes the transaction's results.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && token_kind == TK_END) |-> last_of_run)
    else $error("end result not marked last");

  // Only number results carry a value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && token_kind != TK_NUMBER) |-> (number_value == '0))
    else $error("value on a non-number result");

  // Only plain identifiers carry a length.
  a_length_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && token_kind != TK_IDENT) |-> (ident_length == '0))
    else $error("length on a non-identifier result");

  // A result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(token_kind) && $stable(start_row)))
    else $error("waiting result changed before it was taken");

endmodule

bind source_text_tokenizer stt_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .token_kind   (token_kind),
  .start_row    (start_row),
  .number_value (number_value),
  .ident_length (ident_length),
  .last_of_run  (last_of_run)
);
